FILE: design/ipid_pkg.sv
// Shared types, widths and codes of the incremental PID controller.
package ipid_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int ERR_W          = 33;
    localparam int DIFF_W         = 35;
    localparam int SUM_W          = 64;
    localparam int TICK_W         = 32;
    localparam int SAMPLE_TICKS_W = 16;
    localparam int STATUS_W       = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WAITING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_TICKS = 3'd6;

    // Clamp defaults: +1000.0 and -1000.0 in Q16.16
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd65536000;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd65536000;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] measurement;
        logic [TICK_W-1:0]        now_tick;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic [STATUS_W-1:0]      status;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  gain_p;
        logic signed [DATA_W-1:0]  gain_i;
        logic signed [DATA_W-1:0]  gain_d;
        logic signed [DATA_W-1:0]  setpoint;
        logic signed [DATA_W-1:0]  out_max;
        logic signed [DATA_W-1:0]  out_min;
        logic [SAMPLE_TICKS_W-1:0] sample_ticks;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        gain_p:       '0,
        gain_i:       '0,
        gain_d:       '0,
        setpoint:     '0,
        out_max:      OUT_MAX_RST,
        out_min:      OUT_MIN_RST,
        sample_ticks: '0
    };

endpackage

FILE: design/ipid_cfg_regs.sv
// Configuration register file of the incremental PID controller.
module ipid_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ipid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ipid_pkg::cfg_t                   cfg
);
    import ipid_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAIN_P:       cfg_reg.gain_p       <= $signed(cfg_wdata);
                REG_GAIN_I:       cfg_reg.gain_i       <= $signed(cfg_wdata);
                REG_GAIN_D:       cfg_reg.gain_d       <= $signed(cfg_wdata);
                REG_SETPOINT:     cfg_reg.setpoint     <= $signed(cfg_wdata);
                REG_OUT_MAX:      cfg_reg.out_max      <= $signed(cfg_wdata);
                REG_OUT_MIN:      cfg_reg.out_min      <= $signed(cfg_wdata);
                REG_SAMPLE_TICKS: cfg_reg.sample_ticks <= cfg_wdata[SAMPLE_TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/ipid_gain_term.sv
// One gain term: floor(gain * diff / 2^FRAC_BITS), built from two narrow products.
module ipid_gain_term #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  logic signed [ipid_pkg::DATA_W-1:0] gain,
    input  logic signed [ipid_pkg::DIFF_W-1:0] diff,
    output logic signed [ipid_pkg::SUM_W-1:0]  term
);
    import ipid_pkg::*;

    localparam int HI_W      = DIFF_W - FRAC_BITS;
    localparam int HI_PROD_W = DATA_W + HI_W;
    localparam int LO_PROD_W = DATA_W + FRAC_BITS + 1;
    localparam int LO_SCL_W  = LO_PROD_W - FRAC_BITS;

    logic signed [HI_W-1:0]      diff_hi;
    logic [FRAC_BITS-1:0]        diff_lo;
    logic signed [HI_PROD_W-1:0] prod_hi;
    logic signed [LO_PROD_W-1:0] prod_lo;
    logic signed [LO_SCL_W-1:0]  lo_scaled;

    // Split the difference into a floored high part and an unsigned fraction
    assign diff_hi = $signed(diff[DIFF_W-1:FRAC_BITS]);
    assign diff_lo = diff[FRAC_BITS-1:0];

    // High part lands already scaled; the fraction product is floored
    assign prod_hi   = gain * diff_hi;
    assign prod_lo   = gain * $signed({1'b0, diff_lo});
    assign lo_scaled = $signed(prod_lo[LO_PROD_W-1:FRAC_BITS]);

    assign term = SUM_W'(prod_hi) + SUM_W'(lo_scaled);

endmodule

FILE: design/incremental_pid_controller.sv
// Top level of the incremental (velocity-form) PID controller, Q16.16.
//
//  channel  | ports                      | payload          | role
//  ---------+----------------------------+------------------+-----------------------
//  input    | s_valid, s_ready, s_data   | in_item_t        | sample or clear request
//  result   | m_valid, m_ready, m_data   | out_item_t       | drive and status
//  config   | cfg_wr_en, cfg_addr, ...   | cfg_wdata        | register writes
//
// One request per cycle unless m_ready stalls; requests pass the input register,
// then the result register. The input register feeds three gain multipliers,
// a 64-bit sum and the clamp, which close the output and error-history loop.
// Synchronous reset clears valid flags, controller state and configuration.
// A stall on m_ready holds the result register and then the input register.
module incremental_pid_controller #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ipid_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ipid_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [ipid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ipid_pkg::*;

    cfg_t cfg;

    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    out_item_t out_item_reg;

    logic signed [ERR_W-1:0]  err_prev_reg,  err_prev_next;
    logic signed [ERR_W-1:0]  err_prev2_reg, err_prev2_next;
    logic signed [DATA_W-1:0] out_acc_reg,   out_acc_next;
    logic [TICK_W-1:0]        last_tick_reg, last_tick_next;

    logic                     out_free;
    logic                     fire;
    logic [TICK_W-1:0]        elapsed;
    logic                     waiting;
    logic signed [ERR_W-1:0]  err_cur;
    logic signed [DIFF_W-1:0] diff_p, diff_i, diff_d;
    logic signed [SUM_W-1:0]  term_p, term_i, term_d;
    logic signed [SUM_W-1:0]  sum, sum_hi_lim;
    logic signed [DATA_W-1:0] clamped;
    out_item_t                result;

    ipid_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: advance the input register when the result slot frees up
    assign out_free = !out_vld_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // Sample timing with wrapping elapsed count
    assign elapsed = in_item_reg.now_tick - last_tick_reg;
    assign waiting = elapsed < TICK_W'(cfg.sample_ticks);

    // Error and its differences, all exact
    assign err_cur = ERR_W'(cfg.setpoint) - ERR_W'(in_item_reg.measurement);
    assign diff_p  = DIFF_W'(err_cur) - DIFF_W'(err_prev_reg);
    assign diff_i  = DIFF_W'(err_cur);
    assign diff_d  = DIFF_W'(err_cur) - (DIFF_W'(err_prev_reg) <<< 1)
                   + DIFF_W'(err_prev2_reg);

    ipid_gain_term #(.FRAC_BITS(FRAC_BITS)) u_term_p (
        .gain (cfg.gain_p),
        .diff (diff_p),
        .term (term_p)
    );

    ipid_gain_term #(.FRAC_BITS(FRAC_BITS)) u_term_i (
        .gain (cfg.gain_i),
        .diff (diff_i),
        .term (term_i)
    );

    ipid_gain_term #(.FRAC_BITS(FRAC_BITS)) u_term_d (
        .gain (cfg.gain_d),
        .diff (diff_d),
        .term (term_d)
    );

    // Accumulate and clamp: limit to out_max first, then raise to out_min
    assign sum        = SUM_W'(out_acc_reg) + term_p + term_i + term_d;
    assign sum_hi_lim = (sum > SUM_W'(cfg.out_max)) ? SUM_W'(cfg.out_max) : sum;
    assign clamped    = (sum_hi_lim < SUM_W'(cfg.out_min)) ? cfg.out_min
                                                           : sum_hi_lim[DATA_W-1:0];

    // Select the next state and result for the request in the input register
    always_comb begin
        err_prev_next  = err_prev_reg;
        err_prev2_next = err_prev2_reg;
        out_acc_next   = out_acc_reg;
        last_tick_next = last_tick_reg;
        result.status  = STATUS_WAITING;
        if (in_item_reg.req_type == REQ_CLEAR) begin
            err_prev_next  = '0;
            err_prev2_next = '0;
            out_acc_next   = '0;
            result.status  = STATUS_CLEARED;
        end else if (!waiting) begin
            err_prev_next  = err_cur;
            err_prev2_next = err_prev_reg;
            out_acc_next   = clamped;
            last_tick_next = in_item_reg.now_tick;
            result.status  = STATUS_UPDATED;
        end
        result.drive = out_acc_next;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            out_acc_reg   <= '0;
            last_tick_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg   <= 1'b1;
                err_prev_reg  <= err_prev_next;
                err_prev2_reg <= err_prev2_next;
                out_acc_reg   <= out_acc_next;
                last_tick_reg <= last_tick_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (fire) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

endmodule

FILE: design/ipid_checker.sv
// Port-level assertions for the incremental PID controller, bound to the top level.
module ipid_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ipid_pkg::out_item_t  m_data
);
    import ipid_pkg::*;

    // Reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

    // Only defined status codes leave the block
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STATUS_UPDATED ||
                     m_data.status == STATUS_WAITING ||
                     m_data.status == STATUS_CLEARED))
        else $error("undefined status code");

    // A clear request always reports a zero drive
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_CLEARED) |-> (m_data.drive == '0))
        else $error("clear result with nonzero drive");

    // Input backpressure only comes from a stalled full result slot
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (.*);

FILE: verif/incremental_pid_controller_test.sv
// Self-checking testbench for the incremental PID controller: directed corners, then random phases.
module incremental_pid_controller_test;
    import ipid_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PROD_W      = 72;
    localparam int STUCK_LIMIT = 5000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 150;

    // Tracks controller state and holds the drive/status results still due
    class drive_tracker;
        cfg_t                     regs;
        logic signed [ERR_W-1:0]  err_z1;
        logic signed [ERR_W-1:0]  err_z2;
        logic signed [DATA_W-1:0] drive_acc;
        logic [TICK_W-1:0]        tick_last;
        out_item_t                due_results[$];
        int                       failures;

        function new();
            regs      = CFG_RST;
            err_z1    = '0;
            err_z2    = '0;
            drive_acc = '0;
            tick_last = '0;
            failures  = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_GAIN_P:       regs.gain_p = data;
                REG_GAIN_I:       regs.gain_i = data;
                REG_GAIN_D:       regs.gain_d = data;
                REG_SETPOINT:     regs.setpoint = data;
                REG_OUT_MAX:      regs.out_max = data;
                REG_OUT_MIN:      regs.out_min = data;
                REG_SAMPLE_TICKS: regs.sample_ticks = data[SAMPLE_TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact gain * diff, floored by the fractional shift
        function logic signed [PROD_W-1:0] gain_term(logic signed [DATA_W-1:0] gain,
                                                     logic signed [DIFF_W-1:0] diff);
            logic signed [PROD_W-1:0] g_x;
            logic signed [PROD_W-1:0] d_x;
            g_x = gain;
            d_x = diff;
            return (g_x * d_x) >>> FRAC;
        endfunction

        // Advance the state for one accepted request and queue its result
        function void log_request(in_item_t req);
            logic signed [DIFF_W-1:0] e_x;
            logic signed [DIFF_W-1:0] z1_x;
            logic signed [DIFF_W-1:0] z2_x;
            logic signed [PROD_W-1:0] acc_next;
            logic signed [PROD_W-1:0] top;
            logic signed [PROD_W-1:0] bottom;
            logic [TICK_W-1:0]        elapsed;
            out_item_t                due;
            if (req.req_type == REQ_CLEAR) begin
                err_z1     = '0;
                err_z2     = '0;
                drive_acc  = '0;
                due.status = STATUS_CLEARED;
            end else begin
                elapsed = req.now_tick - tick_last;
                if (elapsed < TICK_W'(regs.sample_ticks)) begin
                    due.status = STATUS_WAITING;
                end else begin
                    e_x      = $signed(regs.setpoint);
                    e_x      = e_x - $signed(req.measurement);
                    z1_x     = err_z1;
                    z2_x     = err_z2;
                    acc_next = drive_acc;
                    acc_next = acc_next
                             + gain_term(regs.gain_p, e_x - z1_x)
                             + gain_term(regs.gain_i, e_x)
                             + gain_term(regs.gain_d, e_x - z1_x - z1_x + z2_x);
                    // Limit to the top first, then raise to the bottom
                    top    = $signed(regs.out_max);
                    bottom = $signed(regs.out_min);
                    if (acc_next > top) acc_next = top;
                    if (acc_next < bottom) acc_next = bottom;
                    drive_acc  = acc_next[DATA_W-1:0];
                    err_z2     = err_z1;
                    err_z1     = e_x[ERR_W-1:0];
                    tick_last  = req.now_tick;
                    due.status = STATUS_UPDATED;
                end
            end
            due.drive = drive_acc;
            due_results.push_back(due);
        endfunction

        // Compare one result with the oldest one due
        function void match_result(out_item_t got);
            out_item_t due;
            if (due_results.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result: drive %h status %0d", got.drive, got.status);
                failures++;
                return;
            end
            due = due_results.pop_front();
            if (got.drive !== due.drive || got.status !== due.status) begin
                if (failures < 10)
                    $display("mismatch: drive exp %h got %h, status exp %0d got %0d",
                             due.drive, got.drive, due.status, got.status);
                failures++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    drive_tracker      tracker;
    int                send_idle_pct = 15;
    int                stall_pct     = 10;
    bit                quiet         = 1'b0;
    int                stall_left    = 0;
    int                stuck_cycles  = 0;
    logic [TICK_W-1:0] tick_now      = '0;

    incremental_pid_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check results and watch for a stuck handshake
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        tracker.set_reg(addr, data);
    endtask

    // Write every register, then drop the write enable
    task automatic load_config(cfg_t c);
        cfg_write(REG_GAIN_P, c.gain_p);
        cfg_write(REG_GAIN_I, c.gain_i);
        cfg_write(REG_GAIN_D, c.gain_d);
        cfg_write(REG_SETPOINT, c.setpoint);
        cfg_write(REG_OUT_MAX, c.out_max);
        cfg_write(REG_OUT_MIN, c.out_min);
        cfg_write(REG_SAMPLE_TICKS, {16'($urandom), c.sample_ticks});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one request, with an optional idle burst ahead of it
    task automatic send_request(in_item_t req);
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 19);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.log_request(req);
    endtask

    // Drop valid and wait for every result due
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    function automatic in_item_t sample_req(logic [DATA_W-1:0] meas, logic [TICK_W-1:0] tick);
        in_item_t req;
        req.req_type    = REQ_SAMPLE;
        req.measurement = meas;
        req.now_tick    = tick;
        return req;
    endfunction

    function automatic in_item_t clear_req();
        in_item_t req;
        req.req_type    = REQ_CLEAR;
        req.measurement = $urandom;
        req.now_tick    = $urandom;
        return req;
    endfunction

    function automatic logic [DATA_W-1:0] random_gain();
        case ($urandom_range(0, 19))
            0:          return 32'h8000_0000;
            1:          return 32'h7FFF_FFFF;
            2:          return '0;
            3, 4, 5, 6: return $urandom;
            default:    return int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t        c;
        logic [31:0] span;
        int          pick;
        c.gain_p = random_gain();
        c.gain_i = random_gain();
        c.gain_d = random_gain();
        if ($urandom_range(0, 3) == 0)
            c.setpoint = $urandom;
        else
            c.setpoint = int'($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
        // Pick a clamp window: wide, narrow, full range, inverted or random
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            span      = $urandom_range(32'h10_0000, 32'h4000_0000);
            c.out_max = span;
            c.out_min = -span;
        end else if (pick < 6) begin
            span      = $urandom_range(1, 32'h10_0000);
            c.out_max = span;
            c.out_min = -span;
        end else if (pick < 8) begin
            c.out_max = 32'h7FFF_FFFF;
            c.out_min = 32'h8000_0000;
        end else if (pick == 8) begin
            span      = $urandom_range(1, 32'h100_0000);
            c.out_max = -span;
            c.out_min = span;
        end else begin
            c.out_max = $urandom;
            c.out_min = $urandom;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            c.sample_ticks = '0;
        else if (pick < 8)
            c.sample_ticks = $urandom_range(1, 64);
        else if (pick == 8)
            c.sample_ticks = 16'hFFFF;
        else
            c.sample_ticks = $urandom;
        return c;
    endfunction

    // Mostly paced samples near the setpoint, some clears and raw noise
    function automatic in_item_t random_request(cfg_t c);
        in_item_t req;
        int       pick;
        pick            = $urandom_range(0, 99);
        req.req_type    = REQ_SAMPLE;
        req.measurement = $urandom;
        req.now_tick    = $urandom;
        if (pick < 4) begin
            req.req_type = REQ_CLEAR;
        end else if (pick >= 10) begin
            tick_now     = tick_now + $urandom_range(0, 2 * c.sample_ticks + 2);
            req.now_tick = tick_now;
            if (pick < 90)
                req.measurement = c.setpoint + int'($urandom_range(0, 32'h20_0000))
                                - 32'sh10_0000;
        end
        return req;
    endfunction

    initial begin
        cfg_t c;
        int   n;
        int   p;
        tracker = new();

        // Hold reset, then release it
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Moderate gains, default clamps: field extremes and a clear
        c          = CFG_RST;
        c.gain_p   = 32'sd65536;
        c.gain_i   = 32'sd32768;
        c.gain_d   = 32'sd16384;
        c.setpoint = 32'sd655360;
        load_config(c);
        send_request(sample_req(32'sd0, 32'd1));
        send_request(sample_req(32'sh7FFF_FFFF, 32'd2));
        send_request(sample_req(32'sh8000_0000, 32'd3));
        send_request(clear_req());
        send_request(sample_req(32'sd327680, 32'd5));
        send_request(sample_req(-32'sd196608, 32'd6));
        drain();

        // Sample pacing: waiting, boundary, tick wrap, clear keeps the tick
        c.sample_ticks = 16'd100;
        load_config(c);
        send_request(sample_req(32'sd0, 32'd50));
        send_request(sample_req(32'sd65536, 32'd106));
        send_request(sample_req(32'sd131072, 32'hFFFF_FFF0));
        send_request(sample_req(32'sd0, 32'h0000_0010));
        send_request(sample_req(32'sd0, 32'h0000_0060));
        send_request(clear_req());
        send_request(sample_req(32'sd0, 32'h0000_0061));
        drain();

        // Inverted clamp window
        c.out_max      = -32'sd327680;
        c.out_min      = 32'sd327680;
        c.sample_ticks = '0;
        load_config(c);
        send_request(sample_req(32'sd0, 32'h70));
        send_request(sample_req(32'sh7FFF_FFFF, 32'h71));
        drain();

        // Extreme gains and setpoint, full clamp range, longest pacing
        c.gain_p       = 32'sh8000_0000;
        c.gain_i       = 32'sh7FFF_FFFF;
        c.gain_d       = 32'sh8000_0000;
        c.setpoint     = 32'sh7FFF_FFFF;
        c.out_max      = 32'sh7FFF_FFFF;
        c.out_min      = 32'sh8000_0000;
        c.sample_ticks = 16'hFFFF;
        load_config(c);
        tick_now = 32'h71 + 32'hFFFF;
        send_request(sample_req(32'sh8000_0000, tick_now));
        send_request(sample_req(32'sh7FFF_FFFF, tick_now + 32'hFFFE));
        tick_now = tick_now + 32'h1_FFFF;
        send_request(sample_req(32'sh8000_0000, tick_now));
        send_request(clear_req());
        tick_now = tick_now + 32'hFFFF;
        send_request(sample_req(32'sh7FFF_FFFF, tick_now));
        drain();

        // Opposite signs of the extremes
        c.gain_p       = 32'sh7FFF_FFFF;
        c.gain_i       = 32'sh8000_0000;
        c.gain_d       = 32'sh7FFF_FFFF;
        c.setpoint     = 32'sh8000_0000;
        c.sample_ticks = '0;
        load_config(c);
        send_request(sample_req(32'sh7FFF_FFFF, tick_now + 1));
        send_request(sample_req(32'sh8000_0000, tick_now + 2));
        drain();

        // Random phases; the last one runs without idling
        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES - 1) begin
                quiet = 1'b1;
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 15;
                    default: send_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            c = random_settings();
            load_config(c);
            if ($urandom_range(0, 3) == 0)
                tick_now = 32'hFFFF_FFFF - $urandom_range(0, 4 * c.sample_ticks + 8);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(c));
            drain();
        end

        repeat (8) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
